@@ sv/msp_pkg.sv @@
`default_nettype none

package msp_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int COUNT_W        = 16;
    localparam int MIN_PRIME      = 2;
    localparam int PC_W           = 3;

    typedef logic [PC_W-1:0] t_pc;

    // Program steps
    localparam t_pc STEP_WAIT_IN   = 3'd0;
    localparam t_pc STEP_SCREEN    = 3'd1;
    localparam t_pc STEP_LOOP_TEST = 3'd2;
    localparam t_pc STEP_DIV_RUN   = 3'd3;
    localparam t_pc STEP_DIV_WAIT  = 3'd4;
    localparam t_pc STEP_REM_CHECK = 3'd5;
    localparam t_pc STEP_FINISH    = 3'd6;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_SMALL,
        COND_SQ_GT,
        COND_DIV_BUSY,
        COND_REM_ZERO,
        COND_OUT_FULL
    } t_cond;

    typedef struct packed {
        logic  take_in;
        logic  init_trial;
        logic  div_start;
        logic  advance;
        logic  finish;
        t_cond cond;
        t_pc   tgt_true;
        t_pc   tgt_false;
    } t_ctl;

    typedef struct packed {
        logic in_valid;
        logic small_sum;
        logic sq_gt;
        logic div_busy;
        logic rem_zero;
        logic out_full;
    } t_stat;

    // Control store: take, init, div, adv, fin, condition, jump if true, jump if false
    function automatic t_ctl ctl_word(input t_pc step);
        t_ctl w;
        w = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_WAIT_IN, STEP_WAIT_IN};
        unique case (step)
            STEP_WAIT_IN:
                w = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, COND_IN_VALID, STEP_SCREEN, STEP_WAIT_IN};
            STEP_SCREEN:
                w = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, COND_SMALL, STEP_FINISH, STEP_LOOP_TEST};
            STEP_LOOP_TEST:
                w = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_SQ_GT, STEP_FINISH, STEP_DIV_RUN};
            STEP_DIV_RUN:
                w = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, COND_ALWAYS, STEP_DIV_WAIT, STEP_DIV_WAIT};
            STEP_DIV_WAIT:
                w = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_DIV_BUSY, STEP_DIV_WAIT,
                      STEP_REM_CHECK};
            STEP_REM_CHECK:
                w = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, COND_REM_ZERO, STEP_FINISH,
                      STEP_LOOP_TEST};
            STEP_FINISH:
                w = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, COND_OUT_FULL, STEP_FINISH, STEP_WAIT_IN};
            default:
                w = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_WAIT_IN, STEP_WAIT_IN};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ sv/msp_seq.sv @@
`default_nettype none

module msp_seq
    import msp_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  t_stat i_stat,
    output t_ctl  o_ctl
);

    t_pc  r_pc;
    t_pc  n_pc;
    t_ctl w;
    logic hit;

    assign w     = ctl_word(r_pc);
    assign o_ctl = w;

    always_comb begin
        unique case (w.cond)
            COND_ALWAYS:   hit = 1'b1;
            COND_IN_VALID: hit = i_stat.in_valid;
            COND_SMALL:    hit = i_stat.small_sum;
            COND_SQ_GT:    hit = i_stat.sq_gt;
            COND_DIV_BUSY: hit = i_stat.div_busy;
            COND_REM_ZERO: hit = i_stat.rem_zero;
            COND_OUT_FULL: hit = i_stat.out_full;
            default:       hit = 1'b1;
        endcase
        n_pc = hit ? w.tgt_true : w.tgt_false;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_WAIT_IN;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

@@ sv/msp_div.sv @@
`default_nettype none

module msp_div
    import msp_pkg::*;
#(
    parameter int DIVIDEND_W = DATA_WIDTH_DEF,
    parameter int DIVISOR_W  = DATA_WIDTH_DEF / 2 + 2
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire  [DIVIDEND_W-1:0] i_dividend,
    input  wire  [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_busy,
    output logic [DIVISOR_W-1:0]  o_rem
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_num;
    logic [DIVISOR_W-1:0]  r_den;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  n_rem;
    logic [DIVISOR_W:0]    trial;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_num[DIVIDEND_W-1]};
        if (trial >= {1'b0, r_den}) begin
            n_rem = DIVISOR_W'(trial - {1'b0, r_den});
        end else begin
            n_rem = trial[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIVIDEND_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

@@ sv/matrix_sum_prime_filter.sv @@
// Adds one pair of matching matrix elements as signed numbers and tests the
// sum for primality by trial division: divisor 2, then 3, 5, 7, ... while the
// divisor squared does not exceed the sum. Sums below two are never prime.
// Each item yields one result: the exact sum, a prime flag and a 16-bit prime
// count that saturates at its maximum; start_of_matrix clears the count before
// the item is counted. One item is worked on at a time. A small microcoded
// sequencer steps through the test, and each trial remainder comes from a
// restoring divider that retires one dividend bit per cycle. A finished item
// waits while the output register is still full. The result sits in an
// output register, so the block accepts the next item while it waits to be
// taken.
`default_nettype none

module matrix_sum_prime_filter
    import msp_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire  signed [DATA_WIDTH-1:0] i_first_value,
    input  wire  signed [DATA_WIDTH-1:0] i_second_value,
    input  wire                         i_start_of_matrix,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic signed [DATA_WIDTH:0]  o_sum_value,
    output logic                        o_is_prime,
    output logic [COUNT_W-1:0]          o_prime_count
);

    localparam int SUM_W = DATA_WIDTH + 1;
    // Trial divisor never passes sqrt(2^DATA_WIDTH) + 2
    localparam int D_W   = (DATA_WIDTH + 1) / 2 + 2;
    // Square of the divisor may overshoot the sum before the loop exits
    localparam int SQ_W  = DATA_WIDTH + 2;

    t_ctl  ctl;
    t_stat stat;

    logic signed [SUM_W-1:0] r_sum;
    logic                    r_start;
    logic                    r_prime;
    logic [D_W-1:0]          r_d;
    logic [SQ_W-1:0]         r_sq;
    logic                    r_out_valid;
    logic signed [SUM_W-1:0] r_out_sum;
    logic                    r_out_prime;
    logic [COUNT_W-1:0]      r_count;
    logic [COUNT_W-1:0]      n_count;
    logic [COUNT_W-1:0]      count_base;

    logic [DATA_WIDTH-1:0]   mag;
    logic                    small_sum;
    logic                    accept;
    logic                    out_full;
    logic                    fire;
    logic                    div_busy;
    logic [D_W-1:0]          div_rem;

    msp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    msp_div #(
        .DIVIDEND_W (DATA_WIDTH),
        .DIVISOR_W  (D_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ctl.div_start),
        .i_dividend (mag),
        .i_divisor  (r_d),
        .o_busy     (div_busy),
        .o_rem      (div_rem)
    );

    // A nonnegative sum fits in the low DATA_WIDTH bits
    assign mag       = r_sum[DATA_WIDTH-1:0];
    assign small_sum = r_sum[SUM_W-1] | (mag < DATA_WIDTH'(MIN_PRIME));

    // Input is open only on the wait step of the program
    assign o_in_stall = ~ctl.take_in;
    assign accept     = ctl.take_in & i_in_valid;

    // Output register frees when its item is taken this cycle
    assign out_full = r_out_valid & i_out_stall;
    assign fire     = ctl.finish & ~out_full;

    assign stat = '{
        in_valid:  i_in_valid,
        small_sum: small_sum,
        sq_gt:     r_sq > SQ_W'(mag),
        div_busy:  div_busy,
        rem_zero:  div_rem == '0,
        out_full:  out_full
    };

    // Clear on start, then count a prime unless already saturated
    always_comb begin
        count_base = r_start ? '0 : r_count;
        if (r_prime && (count_base != '1)) begin
            n_count = count_base + COUNT_W'(1);
        end else begin
            n_count = count_base;
        end
    end

    // Datapath: operands, trial divisor and its square, prime flag
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sum   <= SUM_W'({i_first_value[DATA_WIDTH-1], i_first_value})
                     + SUM_W'({i_second_value[DATA_WIDTH-1], i_second_value});
            r_start <= i_start_of_matrix;
        end
        if (ctl.init_trial) begin
            r_d     <= D_W'(MIN_PRIME);
            r_sq    <= SQ_W'(MIN_PRIME * MIN_PRIME);
            r_prime <= ~small_sum;
        end
        if (ctl.advance) begin
            // Drop the prime flag on an exact divisor
            r_prime <= r_prime & (div_rem != '0);
            if (!r_d[0]) begin
                // 2 -> 3: add 2d + 1
                r_d  <= r_d + D_W'(1);
                r_sq <= r_sq + SQ_W'({r_d, 1'b1});
            end else begin
                // odd d -> d + 2: add 4d + 4
                r_d  <= r_d + D_W'(2);
                r_sq <= r_sq + SQ_W'({r_d, 2'b00}) + SQ_W'(4);
            end
        end
        if (fire) begin
            r_out_sum   <= r_sum;
            r_out_prime <= r_prime;
        end
    end

    // Output handshake and the prime counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_sum_value   = r_out_sum;
    assign o_is_prime    = r_out_prime;
    assign o_prime_count = r_count;

endmodule

`default_nettype wire

@@ sv/msp_chk.sv @@
`default_nettype none

module msp_chk
    import msp_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  o_in_stall,
    input wire                  o_out_valid,
    input wire                  i_out_stall,
    input wire [DATA_WIDTH:0]   o_sum_value,
    input wire                  o_is_prime,
    input wire [COUNT_W-1:0]    o_prime_count
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_sum_value) && $stable(o_is_prime)
            && $stable(o_prime_count))
        else $error("stalled result changed");

    // One item at a time: input closes right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after accept");

    // Prime sums are at least two
    a_prime_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_prime |->
            !o_sum_value[DATA_WIDTH] && (o_sum_value[DATA_WIDTH-1:1] != '0))
        else $error("prime flag on sum below two");

    // The only even prime is two
    a_even_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_prime && !o_sum_value[0] |->
            o_sum_value == (DATA_WIDTH + 1)'(MIN_PRIME))
        else $error("even sum flagged prime");

    // A prime result always carries a nonzero count
    a_count_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_prime |-> o_prime_count != '0)
        else $error("prime with zero count");

endmodule

bind matrix_sum_prime_filter msp_chk #(
    .DATA_WIDTH (DATA_WIDTH)
) u_msp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_sum_value   (o_sum_value),
    .o_is_prime    (o_is_prime),
    .o_prime_count (o_prime_count)
);

`default_nettype wire

@@ test/matrix_sum_prime_filter_tb.sv @@
`default_nettype none

module matrix_sum_prime_filter_tb
    import msp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW          = DATA_WIDTH_DEF;
    localparam int IDLE_LIMIT  = 20000;
    localparam int RAND_ITEMS  = 1150;
    localparam int BURST_ITEMS = 60;     // cheap primes sent flat out

    typedef struct {
        logic signed [DATA_WIDTH_DEF:0] sum;
        logic                           prime;
        logic [COUNT_W-1:0]             count;
    } t_prime_result;

    // Expected-result store plus its own copy of the prime counter.
    class sum_prime_ledger;
        t_prime_result pending_results[$];
        int unsigned   primes_since_start;
        int            errors;

        function new();
            primes_since_start = 0;
            errors = 0;
        endfunction

        function bit sum_is_prime(int n);
            if (n < 2) return 1'b0;
            for (int d = 2; d * d <= n; d++) begin
                if (n % d == 0) return 1'b0;
            end
            return 1'b1;
        endfunction

        task report(string what);
            $display("MISMATCH @%0t: %s", $time, what);
            errors++;
        endtask

        function int waiting();
            return pending_results.size();
        endfunction

        // Predict the result of one accepted item and queue it.
        function void note_pair(logic signed [DATA_WIDTH_DEF-1:0] a,
                                logic signed [DATA_WIDTH_DEF-1:0] b, logic start);
            t_prime_result r;
            r.sum   = a + b;
            r.prime = sum_is_prime(int'(r.sum));
            if (start) primes_since_start = 0;
            if (r.prime && primes_since_start < (1 << COUNT_W) - 1) primes_since_start++;
            r.count = primes_since_start[COUNT_W-1:0];
            pending_results.push_back(r);
        endfunction

        task check_result(logic signed [DATA_WIDTH_DEF:0] sum, logic prime,
                          logic [COUNT_W-1:0] count);
            t_prime_result r;
            if (pending_results.size() == 0) begin
                report($sformatf("result with nothing expected: sum %0d", sum));
                return;
            end
            r = pending_results.pop_front();
            if (sum !== r.sum)
                report($sformatf("sum %0d, expected %0d", sum, r.sum));
            if (prime !== r.prime)
                report($sformatf("is_prime %b for sum %0d, expected %b", prime, r.sum, r.prime));
            if (count !== r.count)
                report($sformatf("prime_count %0d for sum %0d, expected %0d",
                                 count, r.sum, r.count));
        endtask
    endclass

    logic                 i_clk             = 1'b0;
    logic                 i_rst_n           = 1'b0;
    logic                 i_in_valid        = 1'b0;
    logic signed [DW-1:0] i_first_value     = '0;
    logic signed [DW-1:0] i_second_value    = '0;
    logic                 i_start_of_matrix = 1'b0;
    logic                 i_out_stall       = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic signed [DW:0]   o_sum_value;
    logic                 o_is_prime;
    logic [COUNT_W-1:0]   o_prime_count;

    // Idle switches for each side; toggled per phase so some stretches run flat out.
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;

    sum_prime_ledger board = new();

    matrix_sum_prime_filter #(
        .DATA_WIDTH(DW)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_first_value     (i_first_value),
        .i_second_value    (i_second_value),
        .i_start_of_matrix (i_start_of_matrix),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_sum_value       (o_sum_value),
        .o_is_prime        (o_is_prime),
        .o_prime_count     (o_prime_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: count cycles with no handshake on either side.
    int idle_run = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_run = 0;
        end else begin
            idle_run++;
            if (idle_run >= IDLE_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("matrix_sum_prime_filter_tb: errors");
                $finish;
            end
        end
    end

    // Result side: hold stall for a random count per item, then take the next result.
    initial begin
        int hold;
        repeat (7) @(posedge i_clk);
        forever begin
            hold = rx_idle ? $urandom_range(0, 7) : 0;
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            board.check_result(o_sum_value, o_is_prime, o_prime_count);
        end
    end

    // Drive one item; valid stays high into the next call when no gap is drawn.
    task automatic send_pair(input int a, input int b, input bit start);
        int gap;
        logic signed [DW-1:0] fa;
        logic signed [DW-1:0] fb;
        fa  = a[DW-1:0];
        fb  = b[DW-1:0];
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_first_value     <= fa;
        i_second_value    <= fb;
        i_start_of_matrix <= start;
        do @(posedge i_clk); while (o_in_stall);
        board.note_pair(fa, fb, start);
    endtask

    // Split a target sum into two in-range operands at a random point.
    task automatic send_sum(input int target, input bit start);
        int lo;
        int hi;
        int a;
        lo = (target - 32767 > -32768) ? target - 32767 : -32768;
        hi = (target + 32768 < 32767) ? target + 32768 : 32767;
        a  = lo + int'($urandom_range(0, hi - lo));
        send_pair(a, target - a, start);
    endtask

    // Hold off the sender until every expected result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.waiting() != 0);
    endtask

    initial begin
        int pick;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: range extremes, values around two, squares of primes,
        // largest primes and starts that land on a prime or a non-prime.
        send_pair(0, 0, 1'b1);
        send_pair(1, 0, 1'b0);
        send_pair(1, 1, 1'b0);
        send_pair(2, 1, 1'b0);
        send_pair(2, 2, 1'b0);
        send_pair(-3, 5, 1'b0);
        send_pair(-32768, -32768, 1'b0);
        send_pair(32767, 32767, 1'b0);
        send_pair(-1, -1, 1'b0);
        send_pair(32767, -32768, 1'b0);
        send_pair(-21846, 21845, 1'b0);
        send_pair(21845, 10922, 1'b0);
        send_pair(32767, 32754, 1'b0);
        send_pair(32749, 0, 1'b0);
        send_pair(31500, 31501, 1'b0);
        send_pair(32000, 32507, 1'b0);
        send_pair(4, 5, 1'b0);
        send_pair(12, 13, 1'b0);
        send_pair(24, 25, 1'b0);
        send_pair(1, 0, 1'b1);
        send_pair(3, 4, 1'b1);
        send_pair(-32768, 32767, 1'b0);
        drain_results();

        // Burst: run cheap primes flat out on both sides.
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_sum(2, 1'b1);
        for (int i = 0; i < BURST_ITEMS; i++) send_sum(2 + $urandom_range(0, 1), 1'b0);
        send_pair(32767, 32754, 1'b0);
        drain_results();

        // Random mix of full-range operands, large sums and small sums.
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i % 100 == 0) begin
                tx_idle = $urandom_range(0, 3) != 0;
                rx_idle = $urandom_range(0, 3) != 0;
            end
            if (i == RAND_ITEMS / 2) drain_results();
            pick = $urandom_range(0, 9);
            if (pick < 4)
                send_pair(int'($urandom), int'($urandom), $urandom_range(0, 15) == 0);
            else if (pick < 6)
                send_sum($urandom_range(2, 65534), $urandom_range(0, 15) == 0);
            else
                send_sum(int'($urandom_range(0, 1016)) - 16, $urandom_range(0, 15) == 0);
        end

        drain_results();
        repeat (100) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("matrix_sum_prime_filter_tb: clean");
        end else begin
            $display("matrix_sum_prime_filter_tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
